FILE: design/fed_pkg.sv
// Shared constants, types and register codes for the feedback echo delay.
`timescale 1ns / 1ps
`default_nettype none

package fed_pkg;

  // Delay store size and address width.
  localparam int DEPTH  = 32768;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int LAST_W   = 15;
  localparam int ENTRY_W  = 18;
  localparam int FRAC_W   = 15;
  localparam int CFG_W    = 16;

  // Width used to compare the pointer against the last index.
  localparam int CMP_W = ((ADDR_W > LAST_W) ? ADDR_W : LAST_W) + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GAIN   = 2'd0;
  localparam cfg_idx_t CFG_LAST   = 2'd1;
  localparam cfg_idx_t CFG_BYPASS = 2'd2;

  // Register values after reset.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
  localparam logic [LAST_W-1:0] LAST_RESET = 15'd13230;

  // Output full scale.
  localparam int FULL_SCALE = 32767;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       byp;
    logic [ADDR_W-1:0]          addr;
  } fed_item_t;

  // Head of the front queue as seen by the back.
  typedef struct packed {
    logic      valid;
    fed_item_t item;
  } fed_head_t;

endpackage

`default_nettype wire

FILE: design/fed_front.sv
// Front part: accepts samples, assigns store addresses and queues them for the back.
`timescale 1ns / 1ps
`default_nettype none

module fed_front
  import fed_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic [LAST_W-1:0]          last_idx,
  input  wire logic                       bypass,
  input  wire logic                       clr_busy,
  output fed_head_t                       head,
  input  wire logic                       head_pop
);

  fed_item_t         q_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  logic              accept;
  logic              do_pop;
  logic [CMP_W-1:0]  last_eff;
  logic [CMP_W-1:0]  ptr_eff;
  fed_item_t         item;

  localparam logic [CMP_W-1:0] TOP_IDX = CMP_W'(DEPTH - 1);

  assign in_full = (count_r == 2'd2) || clr_busy;
  assign accept  = in_push && !in_full;
  assign do_pop  = head_pop && (count_r != 2'd0);

  // Clamp the last index to the store and restart a pointer that ran past it.
  always_comb begin
    last_eff = (CMP_W'(last_idx) > TOP_IDX) ? TOP_IDX : CMP_W'(last_idx);
    ptr_eff  = (CMP_W'(ptr_r) > TOP_IDX) ? '0 : CMP_W'(ptr_r);
  end

  always_comb begin
    item.sample = in_sample;
    item.byp    = bypass;
    item.addr   = ADDR_W'(ptr_eff);
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (accept && !bypass) begin
      ptr_nxt = (ptr_eff < last_eff) ? ADDR_W'(ptr_eff + CMP_W'(1)) : '0;
    end
  end

  always_comb begin
    wr_ptr_nxt = accept ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(accept) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      ptr_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept)
    else $error("sample accepted while the store is being cleared");

  a_ptr_hold_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && bypass) |=> $stable(ptr_r))
    else $error("pointer moved on a bypass sample");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("front queue count out of range");

endmodule

`default_nettype wire

FILE: design/fed_back.sv
// Back part: delay store, clearing sweep, echo arithmetic and result queue.
`timescale 1ns / 1ps
`default_nettype none

module fed_back
  import fed_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [GAIN_W-1:0]          gain,
  input  wire logic                       clr_start,
  output logic                            clr_busy,
  input  wire fed_head_t                  head,
  output logic                            head_pop,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic signed [SAMPLE_W-1:0]      out_sample
);

  localparam int SUM_W  = ENTRY_W + 1;
  localparam int XS_W   = SAMPLE_W + 1;
  localparam int PROD_W = XS_W + GAIN_W + 1;
  localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'(FULL_SCALE);
  localparam logic signed [SUM_W-1:0]  SUM_MIN    = -SUM_W'(FULL_SCALE);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic [ADDR_W-1:0]        LAST_ADDR  = ADDR_W'(DEPTH - 1);

  // Delay store.
  logic signed [ENTRY_W-1:0] mem [DEPTH];

  // Clearing sweep.
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Execute stage.
  logic                       s2_valid_r;
  fed_item_t                  s2_item_r;
  logic signed [ENTRY_W-1:0]  rd_data_r;
  logic                       fwd_r;
  logic signed [ENTRY_W-1:0]  fwd_data_r;

  // Result queue.
  logic signed [SAMPLE_W-1:0] oq_r [2];
  logic                       oq_wr_r, oq_rd_r;
  logic [1:0]                 oq_count_r, oq_count_nxt;

  logic                       adv;
  logic                       item_we;
  logic                       fwd_hit;
  logic                       oq_push;
  logic                       oq_pop;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_wa;
  logic signed [ENTRY_W-1:0]  mem_wd;

  logic signed [ENTRY_W-1:0]  stored;
  logic signed [SUM_W-1:0]    sum_full;
  logic signed [SAMPLE_W-1:0] clamped;
  logic signed [XS_W-1:0]     xs;
  logic signed [XS_W-1:0]     gain_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [ENTRY_W-1:0]  new_entry;
  logic signed [SAMPLE_W-1:0] result;

  assign clr_busy = clr_active_r;

  // The stage moves whenever no clearing sweep runs and its result has room in the queue.
  assign adv      = !clr_active_r && (!s2_valid_r || (oq_count_r != 2'd2));
  assign head_pop = adv && head.valid;
  assign item_we  = adv && s2_valid_r && !s2_item_r.byp;
  assign fwd_hit  = item_we && head.valid && (s2_item_r.addr == head.item.addr);
  assign oq_push  = adv && s2_valid_r;
  assign oq_pop   = out_pop && !out_empty;

  // Echo arithmetic.
  always_comb begin
    stored   = fwd_r ? fwd_data_r : rd_data_r;
    sum_full = SUM_W'(stored) + SUM_W'(s2_item_r.sample);
    if (sum_full > SUM_MAX) begin
      clamped = SAMPLE_W'(SUM_MAX);
    end else if (sum_full < SUM_MIN) begin
      clamped = SAMPLE_W'(SUM_MIN);
    end else begin
      clamped = SAMPLE_W'(sum_full);
    end
    xs        = XS_W'(s2_item_r.sample) + XS_W'(clamped);
    gain_s    = $signed({1'b0, gain});
    prod      = PROD_W'(gain_s) * PROD_W'(xs);
    rounded   = prod + ROUND_BIAS;
    new_entry = rounded[FRAC_W +: ENTRY_W];
    result    = s2_item_r.byp ? s2_item_r.sample : clamped;
  end

  // Store write port: the sweep has it while clearing.
  always_comb begin
    if (clr_active_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = item_we;
      mem_wa = s2_item_r.addr;
      mem_wd = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (adv) begin
      rd_data_r <= mem[head.item.addr];
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_start) begin
      clr_active_nxt = 1'b1;
      clr_addr_nxt   = '0;
    end else if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  assign oq_count_nxt = oq_count_r + 2'(oq_push) - 2'(oq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s2_valid_r   <= 1'b0;
      fwd_r        <= 1'b0;
      oq_wr_r      <= 1'b0;
      oq_rd_r      <= 1'b0;
      oq_count_r   <= 2'd0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      if (adv) begin
        s2_valid_r <= head.valid;
        fwd_r      <= fwd_hit;
      end
      if (oq_push) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_count_r <= oq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r  <= head.item;
      fwd_data_r <= new_entry;
    end
    if (oq_push) begin
      oq_r[oq_wr_r] <= result;
    end
  end

  assign out_empty  = (oq_count_r == 2'd0);
  assign out_sample = oq_r[oq_rd_r];

  a_clear_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !adv)
    else $error("execute stage moved during the clearing sweep");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_count_r != 2'd3)
    else $error("result queue count out of range");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fwd_hit) |=> (fwd_r && s2_valid_r))
    else $error("forwarded entry captured without a following item");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && !oq_pop) |=> (oq_count_r == $past(oq_count_r) + 2'd1))
    else $error("result queue lost a transfer");

endmodule

`default_nettype wire

FILE: design/feedback_echo_delay.sv
// Top level of the feedback echo delay: configuration registers and the front and back parts.
// Path: front queue, execute stage, result queue, then out_sample.
// Throughput: one sample per cycle while the result queue has room and no sweep runs;
// one store read and write per cycle; a same-address write is forwarded to the read after it.
// Reset: synchronous, active low; registers take their reset values, then a clearing sweep
// writes zero to all DEPTH (32768) store entries, one a cycle, with in_full held high.
// Every write to the bypass register starts the same sweep.
`timescale 1ns / 1ps
`default_nettype none

module feedback_echo_delay
  import fed_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input queue side.
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  // Result queue side.
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  // Configuration write channel.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire cfg_idx_t                   cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data
);

  // Configuration registers. Writes are always taken; the user writes them only
  // while no sample is in flight.
  logic [GAIN_W-1:0] gain_r;
  logic [LAST_W-1:0] last_r;
  logic              bypass_r;

  logic              cfg_xfer;
  logic              clr_start;
  logic              clr_busy;
  fed_head_t         head;
  logic              head_pop;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // A transfer to the bypass register, whatever its value, empties the delay store.
  assign clr_start = cfg_xfer && (cfg_index == CFG_BYPASS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      last_r   <= LAST_RESET;
      bypass_r <= 1'b0;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_LAST:   last_r   <= cfg_data[LAST_W-1:0];
        CFG_BYPASS: bypass_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // The front takes each sample, tags it as bypass or echo, gives echo samples
  // their store address and advances the circular pointer. It keeps a two-entry
  // queue so that the back can stall without stopping the input at once.
  fed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_sample (in_sample),
    .last_idx  (last_r),
    .bypass    (bypass_r),
    .clr_busy  (clr_busy),
    .head      (head),
    .head_pop  (head_pop)
  );

  // The back reads the stored entry, forms the clamped echo (a bypass sample passes as is),
  // writes scaled feedback to the store and queues the result in a two-entry output queue.
  fed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain       (gain_r),
    .clr_start  (clr_start),
    .clr_busy   (clr_busy),
    .head       (head),
    .head_pop   (head_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the feedback echo delay: directed and random sample streams.
`timescale 1ns / 1ps

module testbench;
  import fed_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  // The timeout is far above the slowest correct run. That run is dominated by the clearing
  // sweeps (one after reset and one per bypass write), plus about 1600 samples under random
  // stalls and one long receiver hold.
  localparam int    LIMIT_CYCLES = 2_000_000;
  localparam int    HOLD_CYCLES  = 200;
  localparam int    SETTLE       = 4;
  localparam int    MAX_REPORTS  = 200;
  localparam longint HALF_LSB    = 64'sd1 <<< (FRAC_W - 1);

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  cfg_idx_t                   cfg_index = CFG_GAIN;
  logic [CFG_W-1:0]           cfg_data = '0;

  feedback_echo_delay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_sample  (in_sample),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's state: registers, write pointer and the echo store itself.
  logic [GAIN_W-1:0]          model_gain;
  logic [LAST_W-1:0]          model_last;
  logic                       model_bypass;
  int                         model_ptr;
  logic signed [ENTRY_W-1:0]  echo_store [DEPTH];

  // Samples waiting to be offered, and echoes the block still owes us, oldest first.
  logic signed [SAMPLE_W-1:0] sample_queue [$];
  logic signed [SAMPLE_W-1:0] echoes_due [$];

  int   send_idle_pct = 22;
  int   recv_idle_pct = 48;
  logic in_taken = 1'b0;
  int   errors = 0;
  int   cycle_count = 0;

  // The receiver hold-off is requested by toggling hold_req; its own process counts it down.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  // Works out the echo for one accepted sample and advances the mirrored state. The sum of
  // the sample and the stored entry is clamped to full scale, and the entry is replaced by
  // gain times (sample + clamped sum), rounded to nearest with ties toward plus infinity.
  // In bypass the sample comes back as is and neither the store nor the pointer moves.
  function automatic logic signed [SAMPLE_W-1:0] echo_of(logic signed [SAMPLE_W-1:0] x);
    int     slot;
    int     top;
    int     s;
    longint p;
    if (model_bypass) return x;
    // A last index beyond the store acts as the final entry.
    top  = (int'(model_last) > DEPTH - 1) ? DEPTH - 1 : int'(model_last);
    slot = (model_ptr > DEPTH - 1) ? 0 : model_ptr;
    s = int'(echo_store[slot]) + int'(x);
    if (s > FULL_SCALE) s = FULL_SCALE;
    if (s < -FULL_SCALE) s = -FULL_SCALE;
    p = longint'(model_gain) * longint'(int'(x) + s);
    echo_store[slot] = ENTRY_W'((p + HALF_LSB) >>> FRAC_W);
    // A pointer that sits at or above a freshly lowered last index wraps to zero here.
    model_ptr = (slot < top) ? slot + 1 : 0;
    return SAMPLE_W'(s);
  endfunction

  // Driver: offers the next sample at the falling edge, holding an offer until its transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push   <= 1'b1;
        in_sample <= sample_queue.pop_front();
      end else begin
        in_push   <= 1'b0;
        in_sample <= SAMPLE_W'($urandom);
      end
    end
  end

  // Receiver side: random pops, none at all while a hold-off is running.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold-off counter, so the block fills up and has to push back on the sender.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end
  end

  // Monitor: at each rising edge, a sample transfer queues its predicted echo and a result
  // transfer is checked against the oldest echo still owed.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        echoes_due.push_back(echo_of(in_sample));
      end
      if (out_pop && !out_empty) begin
        if (echoes_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got %0d", $time, out_sample);
        end else begin
          want = echoes_due.pop_front();
          if (out_sample !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_sample expected %0d, got %0d", $time, want, out_sample);
          end
        end
      end
    end
    in_taken <= rst_n && in_push && !in_full;
  end

  // Writes one register and mirrors the write after its transfer.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GAIN: model_gain = data[GAIN_W-1:0];
      CFG_LAST: model_last = data[LAST_W-1:0];
      CFG_BYPASS: begin
        // Any bypass write wipes the store but leaves the pointer where it was.
        model_bypass = data[0];
        foreach (echo_store[i]) echo_store[i] = '0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queues random samples: a mix of full-scale extremes, small values that let the echo
  // build up without clipping, and raw 16-bit patterns so every bit toggles.
  task automatic play(int n);
    logic signed [SAMPLE_W-1:0] v;
    @(posedge clk);
    repeat (n) begin
      case ($urandom_range(7))
        0:       v = 16'sh7FFF;
        1:       v = 16'sh8000;
        2, 3:    v = SAMPLE_W'($urandom_range(4000) - 2000);
        4:       v = SAMPLE_W'($urandom_range(200) - 100);
        default: v = SAMPLE_W'($urandom);
      endcase
      sample_queue.push_back(v);
    end
  endtask

  // Waits until every queued sample has gone in and every echo has come out, then lets the
  // pipeline run dry before anything else happens.
  task automatic drain();
    @(posedge clk);
    while (sample_queue.size() != 0 || in_push || echoes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    model_gain   = GAIN_RESET;
    model_last   = LAST_RESET;
    model_bypass = 1'b0;
    model_ptr    = 0;
    foreach (echo_store[i]) echo_store[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: extremes and bit patterns at the reset settings, the pointer moves to 8.
    @(posedge clk);
    sample_queue = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
                     16'sh5555, 16'shAAAA, 16'sd100};
    drain();

    // Lowering the last index below the pointer forces a wrap to zero on the next sample.
    // A gain just under two drives stored entries to their largest magnitude, and the
    // most negative input meets a store full of large positive echoes.
    write_reg(CFG_LAST, CFG_W'(3));
    write_reg(CFG_GAIN, 16'hFFFF);
    @(posedge clk);
    sample_queue = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    drain();

    // Bypass passes samples straight through; the upper data bits must be ignored.
    write_reg(CFG_BYPASS, {15'h7FFF, 1'b1});
    @(posedge clk);
    sample_queue = '{16'sh8000, 16'sh7FFF, 16'sh1234};
    drain();
    write_reg(CFG_BYPASS, {15'h0000, 1'b0});
    write_reg(CFG_SPARE, CFG_W'($urandom));

    // Random phases, sender idling 22 percent and receiver 48 percent.
    write_reg(CFG_GAIN, 16'h0000);
    write_reg(CFG_LAST, {1'b1, LAST_W'(0)});
    play(120);
    drain();
    write_reg(CFG_GAIN, 16'h8000);
    write_reg(CFG_LAST, CFG_W'(1));
    play(150);
    drain();
    // Half gain makes every odd sum a rounding tie.
    write_reg(CFG_GAIN, 16'h4000);
    write_reg(CFG_LAST, CFG_W'(4));
    play(150);
    drain();

    // Now the sender idles more than the receiver.
    send_idle_pct = 48;
    recv_idle_pct = 22;
    write_reg(CFG_BYPASS, {15'($urandom), 1'b1});
    play(100);
    drain();
    write_reg(CFG_BYPASS, {15'($urandom), 1'b0});
    write_reg(CFG_GAIN, GAIN_W'($urandom_range(65535)));
    write_reg(CFG_LAST, {1'($urandom_range(1)), LAST_W'($urandom_range(40, 2))});
    play(200);
    drain();
    write_reg(CFG_GAIN, 16'hFFFF);
    write_reg(CFG_LAST, {1'b0, LAST_W'(DEPTH - 1)});
    play(120);
    drain();

    // No idling on either side; the receiver holds off once so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_GAIN, GAIN_W'($urandom_range(65535)));
    write_reg(CFG_LAST, CFG_W'($urandom_range(15)));
    play(250);
    hold_req = ~hold_req;
    drain();
    write_reg(CFG_GAIN, GAIN_RESET);
    write_reg(CFG_LAST, {1'($urandom_range(1)), LAST_W'($urandom_range(1000, 100))});
    play(200);
    drain();
    write_reg(CFG_GAIN, GAIN_W'($urandom_range(65535)));
    write_reg(CFG_LAST, LAST_RESET);
    play(260);
    drain();

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("feedback_echo_delay regression: pass");
    end else begin
      $display("feedback_echo_delay regression: fail");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("feedback_echo_delay regression: fail");
    $finish;
  end

endmodule

FILE: feedback_echo_delay.f
design/fed_pkg.sv
design/fed_front.sv
design/fed_back.sv
design/feedback_echo_delay.sv
verif/testbench.sv
